// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled while the
// synchronous reset i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/nprt_pkg.sv =====
// ----------------------------------------------------------------------------
// Name-port registry package
// Types, constants and helper functions shared by the registry cells and the
// top level.
// ----------------------------------------------------------------------------
package nprt_pkg;

    // Default number of table entries, one cell each.
    localparam int TABLE_ENTRIES_DEF = 16;

    // Lengths at or above this value are rejected.
    localparam logic [15:0] MAX_NAME_LEN = 16'd8;

    // Phase of the token walking the cell row.
    typedef enum logic {
        PH_SEARCH,
        PH_COMMIT
    } t_phase;

    // Kind of request, decided when the item is accepted.
    typedef enum logic [1:0] {
        K_NONE,
        K_PORT,
        K_NAME,
        K_REG
    } t_kind;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT,
        S_DONE
    } t_state;

    // Token handed from cell to cell. The search phase collects the first
    // port hit, the first name hit and whether a free entry exists; the
    // commit phase carries the pending write and the owner drop.
    typedef struct packed {
        logic         vld;
        t_phase       phase;
        logic [9:0]   client;
        logic [15:0]  port;
        logic [55:0]  name;
        logic [2:0]   len;
        logic         port_hit;
        logic [2:0]   hit_len;
        logic [55:0]  hit_name;
        logic         name_hit;
        logic [15:0]  hit_port;
        logic         free_seen;
        logic         wr;
        logic         drop;
    } t_tok;

    // Mask that keeps the low n bytes of a 64-bit name.
    function automatic logic [63:0] byte_mask(input logic [2:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < n) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Effective length: the first n bytes, cut at the first zero byte.
    function automatic logic [2:0] eff_len(input logic [63:0] name, input logic [2:0] n);
        logic [2:0] e;
        e = n;
        for (int i = 7; i >= 0; i--) begin
            if ((3'(i) < n) && (name[i*8 +: 8] == 8'h00)) begin
                e = 3'(i);
            end
        end
        return e;
    endfunction

endpackage

// ===== rtl/nprt_cell.sv =====
// ----------------------------------------------------------------------------
// Registry cell
// Holds one table entry and passes the walking token through a register to its right
// neighbor, updating it in the search phase and applying writes and
// owner drops in the commit phase.
// ----------------------------------------------------------------------------
module nprt_cell
    import nprt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic         r_valid;
    logic         n_valid;
    logic [55:0]  r_name;
    logic [2:0]   r_len;
    logic [15:0]  r_port;
    logic [9:0]   r_owner;
    t_tok         r_tok;
    t_tok         n_tok;
    logic         w_write;
    logic         w_name_eq;
    logic         w_port_eq;

    // Compare the entry against the token and work out the update.
    always_comb begin
        n_tok     = i_tok;
        n_valid   = r_valid;
        w_write   = 1'b0;
        w_name_eq = r_valid && (r_len == i_tok.len) && (r_name == i_tok.name);
        w_port_eq = r_valid && (r_port == i_tok.port);
        if (i_tok.vld && (i_tok.phase == PH_SEARCH)) begin
            // Cells to the left hold lower indexes, so the first hit is kept.
            if (w_port_eq && !i_tok.port_hit) begin
                n_tok.port_hit = 1'b1;
                n_tok.hit_len  = r_len;
                n_tok.hit_name = r_name;
            end
            if (w_name_eq && !i_tok.name_hit) begin
                n_tok.name_hit = 1'b1;
                n_tok.hit_port = r_port;
            end
            if (!r_valid) begin
                n_tok.free_seen = 1'b1;
            end
        end
        if (i_tok.vld && (i_tok.phase == PH_COMMIT)) begin
            // The lowest free entry takes the write and retires it.
            if (i_tok.wr && !r_valid) begin
                w_write   = 1'b1;
                n_valid   = 1'b1;
                n_tok.wr  = 1'b0;
            end else if (i_tok.drop && r_valid && (r_owner == i_tok.client)) begin
                n_valid = 1'b0;
            end
        end
    end

    // Entry valid bit and token stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    // Entry contents, written only when the entry is claimed.
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_name  <= i_tok.name;
            r_len   <= i_tok.len;
            r_port  <= i_tok.port;
            r_owner <= i_tok.client;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/name_port_registry_table_top.sv =====
// The token walks the cell row once to search and once to write or drop entries;
// an item that gets no reply skips the search walk and only drops entries.
// A new item is accepted only in the idle state, after the last one has finished its walks.
// The next item is accepted while a result waits; it stalls only when it is done too.
// Reset clears every entry valid bit (table empty) and all handshake state.
// ----------------------------------------------------------------------------
// Name-port registry table
// Row of entry cells with a controller that injects a search token, decides
// the reply from what the token collected, then injects a commit token that
// registers the entry or removes the client's entries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module name_port_registry_table_top
    import nprt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_action,
    input  logic [9:0]   i_client_id,
    input  logic [15:0]  i_port,
    input  logic [15:0]  i_name_len,
    input  logic [63:0]  i_name,
    output logic         o_valid,
    input  logic         i_ready,
    output logic         o_has_reply,
    output logic [15:0]  o_reply_port,
    output logic [15:0]  o_reply_len,
    output logic [63:0]  o_reply_name,
    output logic         o_closed
);

    t_state       r_state;
    t_state       n_state;
    t_tok         r_inj;
    t_tok         n_inj;
    t_tok         w_tok [0:TABLE_ENTRIES];
    t_tok         w_end;

    // Request held for the whole item.
    t_kind        r_kind;
    logic [9:0]   r_client;
    logic [15:0]  r_port;
    logic [2:0]   r_len;
    logic [55:0]  r_en;
    logic [2:0]   r_el;
    logic [63:0]  r_mname;

    // Result waiting for the output register.
    logic         r_res_has;
    logic [15:0]  r_res_port;
    logic [2:0]   r_res_len;
    logic [63:0]  r_res_name;
    logic         r_res_closed;

    // Output register.
    logic         r_ovld;
    logic         r_o_has;
    logic [15:0]  r_o_port;
    logic [2:0]   r_o_len;
    logic [63:0]  r_o_name;
    logic         r_o_closed;

    logic         w_accept;
    logic         w_decide;
    logic         w_load_out;
    t_kind        w_kind;
    logic [2:0]   w_len3;
    logic [2:0]   w_el;
    logic [63:0]  w_en;
    logic         w_reg_ok;
    logic         w_wr;
    logic [15:0]  w_res_port;
    logic [2:0]   w_res_len;
    logic [63:0]  w_res_name;
    logic         w_res_closed;

    // Classify the incoming request and form its effective name.
    always_comb begin
        w_len3 = i_name_len[2:0];
        w_el   = eff_len(i_name, w_len3);
        w_en   = i_name & byte_mask(w_el);
        if (i_action || (i_name_len >= MAX_NAME_LEN)
                || ((i_port == 16'd0) && (i_name_len == 16'd0))) begin
            w_kind = K_NONE;
        end else if (i_name_len == 16'd0) begin
            w_kind = K_PORT;
        end else if (i_port == 16'd0) begin
            w_kind = K_NAME;
        end else begin
            w_kind = K_REG;
        end
    end

    // Decide the reply from the search token returning at the row's end.
    always_comb begin
        w_reg_ok     = !w_end.port_hit && !w_end.name_hit && w_end.free_seen;
        w_wr         = 1'b0;
        w_res_port   = r_port;
        w_res_len    = 3'd0;
        w_res_name   = '0;
        w_res_closed = 1'b1;
        case (r_kind)
            K_PORT: begin
                if (w_end.port_hit) begin
                    w_res_len  = w_end.hit_len;
                    w_res_name = {8'h00, w_end.hit_name};
                end
            end
            K_NAME: begin
                w_res_len  = r_len;
                w_res_name = r_mname;
                w_res_port = w_end.name_hit ? w_end.hit_port : 16'd0;
            end
            K_REG: begin
                if (w_reg_ok) begin
                    w_wr         = 1'b1;
                    w_res_len    = r_len;
                    w_res_name   = r_mname;
                    w_res_closed = 1'b0;
                end
            end
            default: begin
                w_res_port = 16'd0;
            end
        endcase
    end

    // Controller state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, token injection and handshake.
    always_comb begin
        n_state    = r_state;
        n_inj      = '0;
        w_accept   = 1'b0;
        w_decide   = 1'b0;
        w_load_out = 1'b0;
        o_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_accept     = 1'b1;
                    n_inj.vld    = 1'b1;
                    n_inj.client = i_client_id;
                    n_inj.port   = i_port;
                    n_inj.name   = w_en[55:0];
                    n_inj.len    = w_el;
                    if (w_kind == K_NONE) begin
                        // No reply: go straight to dropping the client's entries.
                        n_inj.phase = PH_COMMIT;
                        n_inj.drop  = 1'b1;
                        n_state     = S_COMMIT;
                    end else begin
                        n_inj.phase = PH_SEARCH;
                        n_state     = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_end.vld) begin
                    w_decide     = 1'b1;
                    n_inj.vld    = 1'b1;
                    n_inj.phase  = PH_COMMIT;
                    n_inj.client = r_client;
                    n_inj.port   = r_port;
                    n_inj.name   = r_en;
                    n_inj.len    = r_el;
                    n_inj.wr     = w_wr;
                    n_inj.drop   = !w_wr;
                    n_state      = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_end.vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovld || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Injection register feeding the first cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.vld <= 1'b0;
        end else begin
            r_inj <= n_inj;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= w_kind;
            r_client <= i_client_id;
            r_port   <= i_port;
            r_len    <= w_len3;
            r_en     <= w_en[55:0];
            r_el     <= w_el;
            r_mname  <= i_name & byte_mask(w_len3);
        end
    end

    // Result capture: a rejected item gets the empty closing result at once.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_has    <= 1'b0;
            r_res_port   <= 16'd0;
            r_res_len    <= 3'd0;
            r_res_name   <= '0;
            r_res_closed <= 1'b1;
        end else if (w_decide) begin
            r_res_has    <= 1'b1;
            r_res_port   <= w_res_port;
            r_res_len    <= w_res_len;
            r_res_name   <= w_res_name;
            r_res_closed <= w_res_closed;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_load_out) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_has    <= r_res_has;
            r_o_port   <= r_res_port;
            r_o_len    <= r_res_len;
            r_o_name   <= r_res_name;
            r_o_closed <= r_res_closed;
        end
    end

    // Row of entry cells; index 0 is the lowest table index.
    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        nprt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_end = w_tok[TABLE_ENTRIES];

    assign o_valid      = r_ovld;
    assign o_has_reply  = r_o_has;
    assign o_reply_port = r_o_port;
    assign o_reply_len  = {13'd0, r_o_len};
    assign o_reply_name = r_o_name;
    assign o_closed     = r_o_closed;

    // A token leaves the row only while the controller waits for one.
    `ASSERT_NEVER(a_tok_unexpected, w_end.vld && (r_state == S_IDLE || r_state == S_DONE), "token left the cell row while no walk was pending")

    // The returning token's phase matches the walk the controller started.
    `ASSERT_ALWAYS(a_tok_phase, (w_end.vld && r_state == S_SEARCH) |-> (w_end.phase == PH_SEARCH), "commit token seen during search")

    // A client stays open only after a registration that echoes a nonzero length.
    `ASSERT_ALWAYS(a_open_reply, (r_ovld && !r_o_closed) |-> (r_o_has && r_o_len != 3'd0), "open client without a registration reply")

    // An item without a reply carries an empty record and closes the client.
    `ASSERT_ALWAYS(a_noreply_empty, (r_ovld && !r_o_has) |-> (r_o_port == 16'd0 && r_o_len == 3'd0 && r_o_closed), "item without reply has nonzero fields")

endmodule
